[hdl/rvx_pkg.sv]
package rvx_pkg;

  localparam int unsigned XLEN = 64;

  // Register index of the divider output: stage 2 feeds the first step, one quotient bit
  // per stage after that.
  localparam int unsigned PL_LAST = 2 + XLEN;
  // Stage whose payload picks up the finished product.
  localparam int unsigned MUL_MERGE = 6;
  // Cycles from an accepted start to the edge that accepts its result.
  localparam int unsigned LATENCY = PL_LAST + 1;

  // Major opcodes.
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_IMM32  = 7'h1B;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_REG32  = 7'h3B;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6F;

  // Extended operation field values.
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  // Shift immediate upper bits.
  localparam logic [5:0] TOP6_ARITH = 6'h10;
  localparam logic [6:0] TOP7_ARITH = 7'h20;

  // Minor operation codes of the integer group.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Minor operation codes of the multiply group.
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  // Branch conditions.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Load width code that does not exist in RV64.
  localparam logic [2:0] F3_LD_NONE = 3'd7;

  // Memory access kinds.
  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_STORE = 2'd2;

  typedef enum logic [1:0] {
    CLS_ALU = 2'd0,
    CLS_MUL = 2'd1,
    CLS_DIV = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    MSEL_LO = 2'd0,
    MSEL_HI = 2'd1,
    MSEL_W  = 2'd2
  } msel_t;

  typedef struct packed {
    logic [6:0]         op;
    logic [2:0]         funct3;
    logic [6:0]         funct7;
    logic [63:0]        src1;
    logic [63:0]        src2;
    logic signed [31:0] imm;
    logic [31:0]        pc;
    logic [4:0]         dest_index;
  } in_t;

  typedef struct packed {
    logic [63:0] result;
    logic        write_enable;
    logic [4:0]  write_index;
    logic        redirect;
    logic [31:0] target;
    logic [63:0] mem_address;
    logic [1:0]  access_kind;
    logic        illegal;
  } out_t;

  // Sign fixup and selection applied after the unsigned divider.
  typedef struct packed {
    logic neg_q;
    logic neg_r;
    logic sel_rem;
    logic word;
  } divctl_t;

  // Everything that travels down the pipeline beside the multiplier and divider.
  typedef struct packed {
    out_t    o;
    cls_t    cls;
    msel_t   msel;
    divctl_t dctl;
  } pl_t;

  function automatic logic [63:0] sext32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage

[hdl/rvx_div.sv]
// Unsigned restoring divider, one quotient bit per register stage.
// A new operand pair can enter every cycle; results come from the last step register.
module rvx_div (
  input  logic                     clk,
  input  logic [rvx_pkg::XLEN-1:0] dvd,
  input  logic [rvx_pkg::XLEN-1:0] dvs,
  output logic [rvx_pkg::XLEN-1:0] quo,
  output logic [rvx_pkg::XLEN-1:0] rem
);

  localparam int unsigned W = rvx_pkg::XLEN;

  // Partial remainder, dividend bits shifting out while quotient bits shift in, divisor.
  logic [W-1:0] rem_r [0:W];
  logic [W-1:0] quo_r [0:W];
  logic [W-1:0] dvs_r [0:W];

  // Operand registers.
  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    quo_r[0] <= dvd;
    dvs_r[0] <= dvs;
  end

  // One trial subtraction per stage. The shifted remainder can reach 65 bits when the
  // divisor has its top bit set, so the trial keeps one extra bit for the borrow.
  for (genvar j = 0; j < W; j++) begin : g_step
    logic [W+1:0] trial;

    assign trial = {1'b0, rem_r[j], quo_r[j][W-1]} - {2'b00, dvs_r[j]};

    always_ff @(posedge clk) begin
      dvs_r[j+1] <= dvs_r[j];
      if (!trial[W+1]) begin
        rem_r[j+1] <= trial[W-1:0];
        quo_r[j+1] <= {quo_r[j][W-2:0], 1'b1};
      end else begin
        rem_r[j+1] <= {rem_r[j][W-2:0], quo_r[j][W-1]};
        quo_r[j+1] <= {quo_r[j][W-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_r[W];
  assign rem = rem_r[W];

endmodule

[hdl/rv64im_integer_execute.sv]
// RV64IM execute stage. Every instruction takes the same path through a 67-stage
// pipeline, so results strobe out_valid in the order of their start transfers,
// and one instruction can be started in every cycle; busy is never raised.
// The length comes from the divider, which produces one quotient bit per stage over
// 64 stages; multiplies finish by stage 5 and other operations in the first stage,
// and both wait in the payload pipeline to keep results in order. The receiver cannot
// stall: each result is shown for one cycle only. PC_WIDTH sets where the link
// address wraps (32 to 64); jump targets wrap at 32 bits and target is always the low 32 bits.
module rv64im_integer_execute #(
  parameter int unsigned PC_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rvx_pkg::in_t  in_data,
  output logic          out_valid,
  output rvx_pkg::out_t out_data
);

  localparam logic [63:0] PC_MASK =
    (PC_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << PC_WIDTH) - 64'd1);

  localparam int unsigned LAST = rvx_pkg::PL_LAST;
  localparam int unsigned MRG  = rvx_pkg::MUL_MERGE;

  // Input stage.
  logic         v1_r;
  rvx_pkg::in_t s1_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= in_data;
  end

  // Decode and the operations done in the first stage.
  logic [63:0] a, b, immx, pc64, opnd, link, shl, shr, sha, asum;
  logic [31:0] a32, shlw, shrw, shaw;
  logic [5:0]  amt;
  logic        lt_s, lt_u, take;
  logic [63:0] res, addr;
  logic [31:0] tgt;
  logic        wr, redir, bad, div_sgn, div_word;
  logic [1:0]  kind;
  rvx_pkg::cls_t    cls;
  rvx_pkg::msel_t   msel;
  rvx_pkg::divctl_t dctl;
  logic [63:0] corr, xa, xb, dvd, dvs;
  logic        na, nb;
  rvx_pkg::pl_t pl_in;

  always_comb begin
    a    = s1_r.src1;
    b    = s1_r.src2;
    a32  = a[31:0];
    immx = {{32{s1_r.imm[31]}}, s1_r.imm};
    pc64 = {32'd0, s1_r.pc};
    opnd = (s1_r.op == rvx_pkg::OP_IMM) ? immx : b;
    amt  = (s1_r.op == rvx_pkg::OP_IMM || s1_r.op == rvx_pkg::OP_IMM32) ?
           s1_r.imm[5:0] : b[5:0];
    shl  = a << amt;
    shr  = a >> amt;
    sha  = $signed(a) >>> amt;
    shlw = a32 << amt[4:0];
    shrw = a32 >> amt[4:0];
    shaw = $signed(a32) >>> amt[4:0];
    lt_s = $signed(a) < $signed(opnd);
    lt_u = a < opnd;
    asum = a + immx;
    link = (pc64 + 64'd4) & PC_MASK;

    res      = '0;
    addr     = '0;
    tgt      = '0;
    wr       = 1'b0;
    redir    = 1'b0;
    bad      = 1'b0;
    take     = 1'b0;
    kind     = rvx_pkg::ACC_NONE;
    cls      = rvx_pkg::CLS_ALU;
    msel     = rvx_pkg::MSEL_LO;
    corr     = '0;
    div_sgn  = 1'b0;
    div_word = 1'b0;
    dctl     = '0;

    case (s1_r.op)
      rvx_pkg::OP_REG, rvx_pkg::OP_IMM: begin
        wr = 1'b1;
        if (s1_r.op == rvx_pkg::OP_REG && s1_r.funct7 == rvx_pkg::F7_MULDIV) begin
          if (!s1_r.funct3[2]) begin
            cls = rvx_pkg::CLS_MUL;
            case (s1_r.funct3)
              rvx_pkg::F3_MUL:    msel = rvx_pkg::MSEL_LO;
              rvx_pkg::F3_MULH: begin
                msel = rvx_pkg::MSEL_HI;
                corr = (a[63] ? b : 64'd0) + (b[63] ? a : 64'd0);
              end
              rvx_pkg::F3_MULHSU: begin
                msel = rvx_pkg::MSEL_HI;
                corr = a[63] ? b : 64'd0;
              end
              default:            msel = rvx_pkg::MSEL_HI;
            endcase
          end else begin
            cls          = rvx_pkg::CLS_DIV;
            div_sgn      = (s1_r.funct3 == rvx_pkg::F3_DIV) ||
                           (s1_r.funct3 == rvx_pkg::F3_REM);
            dctl.sel_rem = (s1_r.funct3 == rvx_pkg::F3_REM) ||
                           (s1_r.funct3 == rvx_pkg::F3_REMU);
          end
        end else if (s1_r.op == rvx_pkg::OP_REG && s1_r.funct7 == rvx_pkg::F7_ALT) begin
          if (s1_r.funct3 == rvx_pkg::F3_ADD) begin
            res = a - b;
          end else if (s1_r.funct3 == rvx_pkg::F3_SRL) begin
            res = sha;
          end else begin
            bad = 1'b1;
          end
        end else if (s1_r.op == rvx_pkg::OP_REG && s1_r.funct7 != rvx_pkg::F7_BASE) begin
          bad = 1'b1;
        end else begin
          case (s1_r.funct3)
            rvx_pkg::F3_ADD:  res = a + opnd;
            rvx_pkg::F3_SLL: begin
              if (s1_r.op == rvx_pkg::OP_IMM && s1_r.imm[11:6] != 6'd0) bad = 1'b1;
              res = shl;
            end
            rvx_pkg::F3_SLT:  res = {63'd0, lt_s};
            rvx_pkg::F3_SLTU: res = {63'd0, lt_u};
            rvx_pkg::F3_XOR:  res = a ^ opnd;
            rvx_pkg::F3_SRL: begin
              if (s1_r.op == rvx_pkg::OP_REG || s1_r.imm[11:6] == 6'd0) begin
                res = shr;
              end else if (s1_r.imm[11:6] == rvx_pkg::TOP6_ARITH) begin
                res = sha;
              end else begin
                bad = 1'b1;
              end
            end
            rvx_pkg::F3_OR:   res = a | opnd;
            default:          res = a & opnd;
          endcase
        end
      end

      rvx_pkg::OP_REG32: begin
        wr = 1'b1;
        if (s1_r.funct7 == rvx_pkg::F7_BASE && s1_r.funct3 == rvx_pkg::F3_ADD) begin
          res = rvx_pkg::sext32(a32 + b[31:0]);
        end else if (s1_r.funct7 == rvx_pkg::F7_BASE && s1_r.funct3 == rvx_pkg::F3_SLL) begin
          res = rvx_pkg::sext32(shlw);
        end else if (s1_r.funct7 == rvx_pkg::F7_BASE && s1_r.funct3 == rvx_pkg::F3_SRL) begin
          res = rvx_pkg::sext32(shrw);
        end else if (s1_r.funct7 == rvx_pkg::F7_ALT && s1_r.funct3 == rvx_pkg::F3_ADD) begin
          res = rvx_pkg::sext32(a32 - b[31:0]);
        end else if (s1_r.funct7 == rvx_pkg::F7_ALT && s1_r.funct3 == rvx_pkg::F3_SRL) begin
          res = rvx_pkg::sext32(shaw);
        end else if (s1_r.funct7 == rvx_pkg::F7_MULDIV && s1_r.funct3 == rvx_pkg::F3_MUL) begin
          cls  = rvx_pkg::CLS_MUL;
          msel = rvx_pkg::MSEL_W;
        end else if (s1_r.funct7 == rvx_pkg::F7_MULDIV && s1_r.funct3[2]) begin
          cls          = rvx_pkg::CLS_DIV;
          div_word     = 1'b1;
          dctl.word    = 1'b1;
          div_sgn      = (s1_r.funct3 == rvx_pkg::F3_DIV) ||
                         (s1_r.funct3 == rvx_pkg::F3_REM);
          dctl.sel_rem = (s1_r.funct3 == rvx_pkg::F3_REM) ||
                         (s1_r.funct3 == rvx_pkg::F3_REMU);
        end else begin
          bad = 1'b1;
        end
      end

      rvx_pkg::OP_IMM32: begin
        wr = 1'b1;
        if (s1_r.funct3 == rvx_pkg::F3_ADD) begin
          res = rvx_pkg::sext32(asum[31:0]);
        end else if (s1_r.funct3 == rvx_pkg::F3_SLL && s1_r.imm[11:5] == 7'd0) begin
          res = rvx_pkg::sext32(shlw);
        end else if (s1_r.funct3 == rvx_pkg::F3_SRL && s1_r.imm[11:5] == 7'd0) begin
          res = rvx_pkg::sext32(shrw);
        end else if (s1_r.funct3 == rvx_pkg::F3_SRL &&
                     s1_r.imm[11:5] == rvx_pkg::TOP7_ARITH) begin
          res = rvx_pkg::sext32(shaw);
        end else begin
          bad = 1'b1;
        end
      end

      rvx_pkg::OP_LUI: begin
        wr  = 1'b1;
        res = immx;
      end

      rvx_pkg::OP_AUIPC: begin
        wr  = 1'b1;
        res = pc64 + immx;
      end

      rvx_pkg::OP_JAL: begin
        wr    = 1'b1;
        res   = link;
        redir = 1'b1;
        tgt   = s1_r.pc + s1_r.imm;
      end

      rvx_pkg::OP_JALR: begin
        if (s1_r.funct3 != 3'd0) begin
          bad = 1'b1;
        end else begin
          wr    = 1'b1;
          res   = link;
          redir = 1'b1;
          tgt   = {asum[31:1], 1'b0};
        end
      end

      rvx_pkg::OP_BRANCH: begin
        case (s1_r.funct3)
          rvx_pkg::F3_BEQ:  take = (a == b);
          rvx_pkg::F3_BNE:  take = (a != b);
          rvx_pkg::F3_BLT:  take = lt_s;
          rvx_pkg::F3_BGE:  take = !lt_s;
          rvx_pkg::F3_BLTU: take = lt_u;
          rvx_pkg::F3_BGEU: take = !lt_u;
          default:          bad  = 1'b1;
        endcase
        redir = take;
        if (take) tgt = s1_r.pc + s1_r.imm;
      end

      rvx_pkg::OP_LOAD: begin
        if (s1_r.funct3 == rvx_pkg::F3_LD_NONE) begin
          bad = 1'b1;
        end else begin
          kind = rvx_pkg::ACC_LOAD;
          addr = asum;
        end
      end

      rvx_pkg::OP_STORE: begin
        if (s1_r.funct3[2]) begin
          bad = 1'b1;
        end else begin
          kind = rvx_pkg::ACC_STORE;
          addr = asum;
        end
      end

      default: bad = 1'b1;
    endcase

    // Unknown encodings report nothing but the flag and the index.
    if (bad) begin
      res   = '0;
      wr    = 1'b0;
      redir = 1'b0;
      tgt   = '0;
      addr  = '0;
      kind  = rvx_pkg::ACC_NONE;
      cls   = rvx_pkg::CLS_ALU;
    end

    // Divider operands as magnitudes, with the sign fixup for the end of the pipe.
    xa = div_word ? (div_sgn ? rvx_pkg::sext32(a32) : {32'd0, a32}) : a;
    xb = div_word ? (div_sgn ? rvx_pkg::sext32(b[31:0]) : {32'd0, b[31:0]}) : b;
    na = div_sgn && xa[63];
    nb = div_sgn && xb[63];
    dvd = na ? (64'd0 - xa) : xa;
    dvs = nb ? (64'd0 - xb) : xb;
    dctl.neg_q = (na ^ nb) && (xb != 64'd0);
    dctl.neg_r = na;

    pl_in.o.result       = res;
    pl_in.o.write_enable = wr && (s1_r.dest_index != 5'd0);
    pl_in.o.write_index  = s1_r.dest_index;
    pl_in.o.redirect     = redir;
    pl_in.o.target       = tgt;
    pl_in.o.mem_address  = addr;
    pl_in.o.access_kind  = kind;
    pl_in.o.illegal      = bad;
    pl_in.cls            = cls;
    pl_in.msel           = msel;
    pl_in.dctl           = dctl;
  end

  // Payload pipeline with its valid bits.
  logic         pv_r [2:LAST];
  rvx_pkg::pl_t pl_r [2:LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r[2] <= 1'b0;
    end else begin
      pv_r[2] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pl_r[2] <= pl_in;
  end

  // Multiplier: four 32x32 partial products, then the middle column, then the high word.
  logic [63:0] ma_r, mb_r, corr2_r;
  logic [63:0] ll_r, lh_r, hl_r, hh_r, corr3_r;
  logic [33:0] mid_r;
  logic [31:0] lo4_r, lhh_r, hlh_r;
  logic [63:0] hh4_r, corr4_r;
  logic [63:0] hi5_r, low5_r;
  rvx_pkg::pl_t pl_mul;

  always_ff @(posedge clk) begin
    ma_r    <= a;
    mb_r    <= b;
    corr2_r <= corr;

    ll_r    <= ma_r[31:0] * mb_r[31:0];
    lh_r    <= ma_r[31:0] * mb_r[63:32];
    hl_r    <= ma_r[63:32] * mb_r[31:0];
    hh_r    <= ma_r[63:32] * mb_r[63:32];
    corr3_r <= corr2_r;

    mid_r   <= {2'd0, ll_r[63:32]} + {2'd0, lh_r[31:0]} + {2'd0, hl_r[31:0]};
    lo4_r   <= ll_r[31:0];
    lhh_r   <= lh_r[63:32];
    hlh_r   <= hl_r[63:32];
    hh4_r   <= hh_r;
    corr4_r <= corr3_r;

    hi5_r   <= hh4_r + {32'd0, lhh_r} + {32'd0, hlh_r} + {62'd0, mid_r[33:32]} - corr4_r;
    low5_r  <= {mid_r[31:0], lo4_r};
  end

  // Finished product joins the payload.
  always_comb begin
    pl_mul = pl_r[MRG-1];
    case (pl_r[MRG-1].msel)
      rvx_pkg::MSEL_HI: pl_mul.o.result = hi5_r;
      rvx_pkg::MSEL_W:  pl_mul.o.result = rvx_pkg::sext32(low5_r[31:0]);
      default:          pl_mul.o.result = low5_r;
    endcase
  end

  for (genvar k = 3; k <= LAST; k++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[k] <= 1'b0;
      end else begin
        pv_r[k] <= pv_r[k-1];
      end
    end

    if (k == MRG) begin : g_merge
      always_ff @(posedge clk) begin
        pl_r[k] <= (pl_r[k-1].cls == rvx_pkg::CLS_MUL) ? pl_mul : pl_r[k-1];
      end
    end else begin : g_move
      always_ff @(posedge clk) begin
        pl_r[k] <= pl_r[k-1];
      end
    end
  end

  // Divider, aligned so that its result meets the payload at the last stage.
  logic [63:0] quo, rem, qs, rs, dres;
  rvx_pkg::out_t out_data_nxt;

  rvx_div u_div (
    .clk (clk),
    .dvd (dvd),
    .dvs (dvs),
    .quo (quo),
    .rem (rem)
  );

  always_comb begin
    qs   = pl_r[LAST].dctl.neg_q ? (64'd0 - quo) : quo;
    rs   = pl_r[LAST].dctl.neg_r ? (64'd0 - rem) : rem;
    dres = pl_r[LAST].dctl.sel_rem ? rs : qs;
    if (pl_r[LAST].dctl.word) dres = rvx_pkg::sext32(dres[31:0]);
    out_data_nxt = pl_r[LAST].o;
    if (pl_r[LAST].cls == rvx_pkg::CLS_DIV) out_data_nxt.result = dres;
  end

  // Output register.
  logic          out_valid_r;
  rvx_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pv_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/rvx_chk.sv]
// Port-level checks for the execute stage.
module rvx_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input rvx_pkg::in_t  in_data,
  input logic          out_valid,
  input rvx_pkg::out_t out_data
);

  // The stage never refuses a transfer.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // Every result matches an earlier start transfer.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, rvx_pkg::LATENCY))
    else $error("result without matching start transfer");

  // An illegal encoding carries nothing but its index.
  a_illegal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.illegal) |->
      (out_data.result == 64'd0 && !out_data.write_enable && !out_data.redirect &&
       out_data.target == 32'd0 && out_data.mem_address == 64'd0 &&
       out_data.access_kind == rvx_pkg::ACC_NONE))
    else $error("illegal result not cleared");

  // Register zero is never written.
  a_no_x0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.write_enable) |-> (out_data.write_index != 5'd0))
    else $error("write to register zero");

  // A memory access neither writes a register nor redirects.
  a_mem_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.access_kind != rvx_pkg::ACC_NONE) |->
      (!out_data.write_enable && !out_data.redirect && out_data.result == 64'd0))
    else $error("memory access with register or pc effect");

endmodule

bind rv64im_integer_execute rvx_chk u_chk (.*);
